// ===== rtl/igbc_pkg.sv =====
// Shared types and constants for the gyro bias calibrate/correct block.
// Used by igbc_lane and the top level imu_gyro_bias_calibrate_correct.
// No dependencies.
`default_nettype none

package igbc_pkg;

  // Calibration run length in attempts
  localparam logic [7:0] CAL_ATTEMPTS = 8'd100;

  // Restoring divider: one quotient bit per cycle over the 24-bit sum
  localparam int SUM_W     = 24;
  localparam int DIV_STEPS = SUM_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [1:0] REG_MIN_GOOD   = 2'd0;
  localparam logic [1:0] REG_GYRO_GAIN  = 2'd1;
  localparam logic [1:0] REG_ACCEL_GAIN = 2'd2;

  // Register reset values
  localparam logic [7:0]  MIN_GOOD_RST   = 8'd90;
  localparam logic [15:0] GYRO_GAIN_RST  = 16'd74;
  localparam logic [15:0] ACCEL_GAIN_RST = 16'd5780;

  // Per-cycle controls broadcast from the sequencer to the axis lanes
  typedef struct packed {
    logic cal_exec;  // a calibration attempt updates state this cycle
    logic start;     // first attempt of a run: clear sums and bias
    logic ok;        // sensor read of this word succeeded
    logic fail;      // run ends with too few good reads: zero bias
    logic meas;      // measurement word with good read: drive products
    logic div_load;  // load dividend for the bias division
    logic div_step;  // advance the divider by one quotient bit
    logic div_last;  // final divider step: write the bias
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/igbc_lane.sv =====
// One axis lane: gyro sum, bias register, bit-serial bias divider and the
// corrected rate and acceleration products. Depends on igbc_pkg.
`default_nettype none

module igbc_lane
  import igbc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lane_ctl_t          ctl,
  input  wire logic signed [15:0] gyro,
  input  wire logic signed [7:0]  acc,
  input  wire logic [7:0]         divisor,
  input  wire logic [15:0]        gyro_gain,
  input  wire logic [15:0]        accel_gain,
  output logic signed [31:0]      rate,
  output logic signed [23:0]      lin_acc
);

  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W-1:0] sum_nxt;
  logic signed [15:0]      bias_r;
  logic [SUM_W-1:0]        quo_r;
  logic [SUM_W-1:0]        quo_nxt;
  logic [7:0]              rem_r;
  logic [7:0]              rem_nxt;
  logic                    neg_r;
  logic [8:0]              shifted;
  logic [9:0]              trial;
  logic                    qbit;
  logic [15:0]             bias_q;
  logic signed [15:0]      corr;
  logic signed [32:0]      rate_full;
  logic signed [24:0]      acc_full;

  // Wrapping sum of good reads, restarted on the first attempt of a run
  assign sum_base = ctl.start ? '0 : sum_r;
  assign sum_nxt  = ctl.ok ? sum_base + {{(SUM_W-16){gyro[15]}}, gyro} : sum_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (ctl.cal_exec) begin
      sum_r <= sum_nxt;
    end
  end

  // Restoring division of |sum| by the good count, one bit per cycle
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign trial   = {1'b0, shifted} - {2'b00, divisor};
  assign qbit    = ~trial[9];
  assign rem_nxt = qbit ? trial[7:0] : shifted[7:0];
  assign quo_nxt = {quo_r[SUM_W-2:0], qbit};

  always_ff @(posedge clk) begin
    if (ctl.div_load) begin
      neg_r <= sum_nxt[SUM_W-1];
      quo_r <= sum_nxt[SUM_W-1] ? SUM_W'(-sum_nxt) : sum_nxt;
      rem_r <= '0;
    end else if (ctl.div_step) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Restore sign (truncation toward zero) and keep the low 16 bits
  assign bias_q = neg_r ? (16'd0 - quo_nxt[15:0]) : quo_nxt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bias_r <= '0;
    end else if (ctl.cal_exec && (ctl.start || ctl.fail)) begin
      bias_r <= '0;
    end else if (ctl.div_last) begin
      bias_r <= bias_q;
    end
  end

  // Corrected rate and acceleration, exact products
  assign corr      = gyro - bias_r;
  assign rate_full = corr * $signed({1'b0, gyro_gain});
  assign acc_full  = acc * $signed({1'b0, accel_gain});
  assign rate      = ctl.meas ? rate_full[31:0] : '0;
  assign lin_acc   = ctl.meas ? acc_full[23:0] : '0;

endmodule

`default_nettype wire

// ===== rtl/imu_gyro_bias_calibrate_correct.sv =====
// Top level of the gyro bias calibrate/correct block: stream ports, run
// sequencer, configuration registers, three axis lanes and the output merge.
// Depends on igbc_pkg and igbc_lane.
//
// An input word is taken into an input register and processed from there,
// and no new word is accepted while a measurement word or an ordinary
// calibration attempt is in process. The attempt that closes a successful
// run with a nonzero good count also runs the bias division, one quotient
// bit per cycle in all three lanes at once, and no word is accepted before
// the division ends. The result word is held in an output register, and the
// next input word is accepted while it waits; a word that finds the output
// register still full waits in the input register.
`default_nettype none

module imu_gyro_bias_calibrate_correct
  import igbc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Configuration write channel
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  // Input stream
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // tdata: gyro_x[15:0], gyro_y[31:16], gyro_z[47:32],
  //        acc_x[55:48], acc_y[63:56], acc_z[71:64]
  input  wire logic [71:0]  in_tdata,
  // tuser: mode[0], read_ok[1]
  input  wire logic [1:0]   in_tuser,
  // Result stream
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // tdata: rate_x[31:0], rate_y[63:32], rate_z[95:64],
  //        lin_acc_x[119:96], lin_acc_y[143:120], lin_acc_z[167:144]
  output logic [167:0]      out_tdata,
  // tuser: measurement_valid[0], calibrated[1]
  output logic [1:0]        out_tuser,
  // tlast: calibration_done, marks the attempt that ends a run
  output logic              out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r;

  logic [7:0]  min_good_r;
  logic [15:0] gyro_gain_r;
  logic [15:0] accel_gain_r;

  logic               mode_r;
  logic               ok_r;
  logic signed [15:0] gyro_r [3];
  logic signed [7:0]  acc_r  [3];

  logic [7:0] attempt_r;
  logic [7:0] good_r;
  logic       is_cal_r;

  logic       in_go;
  logic       exec_go;
  logic       cal_go;
  logic       run_start;
  logic [7:0] good_base;
  logic [7:0] good_nxt;
  logic [7:0] attempt_inc;
  logic       run_end;
  logic       pass;
  logic       div_need;
  logic       div_last;
  logic       is_cal_nxt;
  lane_ctl_t  ctl;

  logic signed [31:0] rate    [3];
  logic signed [23:0] lin_acc [3];

  logic         out_valid_r;
  logic [167:0] out_data_r;
  logic [1:0]   out_user_r;
  logic         out_last_r;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_good_r   <= MIN_GOOD_RST;
      gyro_gain_r  <= GYRO_GAIN_RST;
      accel_gain_r <= ACCEL_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_MIN_GOOD:   min_good_r   <= cfg_data[7:0];
        REG_GYRO_GAIN:  gyro_gain_r  <= cfg_data;
        REG_ACCEL_GAIN: accel_gain_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register: hold the word while it is processed
  assign in_tready = (state_r == ST_IDLE);
  assign in_go     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (in_go) begin
      mode_r    <= in_tuser[0];
      ok_r      <= in_tuser[1];
      gyro_r[0] <= in_tdata[15:0];
      gyro_r[1] <= in_tdata[31:16];
      gyro_r[2] <= in_tdata[47:32];
      acc_r[0]  <= in_tdata[55:48];
      acc_r[1]  <= in_tdata[63:56];
      acc_r[2]  <= in_tdata[71:64];
    end
  end

  // Run bookkeeping for a calibration attempt
  assign exec_go     = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign cal_go      = exec_go && mode_r;
  assign run_start   = (attempt_r == 8'd0);
  assign good_base   = run_start ? 8'd0 : good_r;
  assign good_nxt    = good_base + {7'd0, ok_r};
  assign attempt_inc = attempt_r + 8'd1;
  assign run_end     = (attempt_inc >= CAL_ATTEMPTS) || (attempt_inc == 8'd0);
  assign pass        = (good_nxt >= min_good_r);
  assign div_need    = run_end && pass && (good_nxt != 8'd0);
  assign div_last    = (state_r == ST_DIV) && (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1));
  assign is_cal_nxt  = (mode_r && run_end) ? pass : is_cal_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attempt_r <= '0;
      good_r    <= '0;
      is_cal_r  <= 1'b0;
    end else if (cal_go) begin
      attempt_r <= run_end ? 8'd0 : attempt_inc;
      good_r    <= good_nxt;
      if (run_end) begin
        is_cal_r <= pass;
      end
    end
  end

  // Sequencer: idle, process the held word, divide
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_go) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = (mode_r && div_need) ? ST_DIV : ST_IDLE;
      ST_DIV:  if (div_last) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_DIV) begin
        div_cnt_r <= div_cnt_r + DIV_CNT_W'(1);
      end else begin
        div_cnt_r <= '0;
      end
    end
  end

  // Lane controls
  always_comb begin
    ctl.cal_exec = cal_go;
    ctl.start    = run_start;
    ctl.ok       = ok_r;
    ctl.fail     = run_end && !pass;
    ctl.meas     = !mode_r && ok_r;
    ctl.div_load = cal_go && div_need;
    ctl.div_step = (state_r == ST_DIV);
    ctl.div_last = div_last;
  end

  // Three axis lanes side by side
  for (genvar g = 0; g < 3; g++) begin : g_lane
    igbc_lane u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .gyro       (gyro_r[g]),
      .acc        (acc_r[g]),
      .divisor    (good_r),
      .gyro_gain  (gyro_gain_r),
      .accel_gain (accel_gain_r),
      .rate       (rate[g]),
      .lin_acc    (lin_acc[g])
    );
  end

  // Merge lane results into the output word and hold it until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (exec_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_go) begin
      out_data_r <= {lin_acc[2], lin_acc[1], lin_acc[0], rate[2], rate[1], rate[0]};
      out_user_r <= {is_cal_nxt, !mode_r && ok_r};
      out_last_r <= mode_r && run_end;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
